### rtl/itoa_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes and the shift-and-add-3 helper functions.
// No dependencies.
`default_nettype none

package itoa_pkg;

	localparam int MagW          = 32;
	localparam int NumDigits     = 10;
	localparam int BcdW          = 4 * NumDigits;
	localparam int StepsPerStage = 8;
	localparam int DigitIdxW     = $clog2(NumDigits);

	localparam logic [7:0] CharZero  = 8'd48;
	localparam logic [7:0] CharMinus = 8'd45;

	// Partial conversion result: BCD digits built so far and binary bits still to shift in.
	typedef struct packed {
		logic [BcdW-1:0] bcd;
		logic [MagW-1:0] bin;
	} dd_t;

	// Run a group of shift-and-add-3 steps on one partial result.
	function automatic dd_t dd_steps(dd_t din);
		dd_t d;
		d = din;
		for (int s = 0; s < StepsPerStage; s++) begin
			for (int k = 0; k < NumDigits; k++) begin
				if (d.bcd[k*4 +: 4] >= 4'd5) begin
					d.bcd[k*4 +: 4] = d.bcd[k*4 +: 4] + 4'd3;
				end
			end
			d.bcd = {d.bcd[BcdW-2:0], d.bin[MagW-1]};
			d.bin = {d.bin[MagW-2:0], 1'b0};
		end
		return d;
	endfunction

	// Index of the most significant nonzero digit, zero when all digits are zero.
	function automatic logic [DigitIdxW-1:0] top_digit(logic [BcdW-1:0] bcd);
		logic [DigitIdxW-1:0] t;
		t = '0;
		for (int k = 0; k < NumDigits; k++) begin
			if (bcd[k*4 +: 4] != 4'd0) begin
				t = DigitIdxW'(k);
			end
		end
		return t;
	endfunction

endpackage

`default_nettype wire

### rtl/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text converter, top level.
// Depends on itoa_pkg for widths, character codes and the BCD step functions.
//
// Usage:
//   Input channel (value, value_valid, value_stall) takes one signed 32-bit value per
//   transaction. Output channel (text_char, last_char, text_valid, text_stall) gives the
//   decimal text one character per transaction: an optional '-', then the digits from
//   most significant down without leading zeros; last_char marks the final character.
//   Zero gives the single character '0'.
// Pipeline: one stage forms the magnitude, four stages of eight shift-and-add-3 steps
//   build the BCD digits, then the character serializer loads the converted value.
// Throughput: one character per cycle on the output while text_stall is low, so a value
//   occupies the output for its character count, one to eleven characters; the next
//   value's first character follows the previous last character with no gap when that
//   value is already waiting in the last stage. The single-character output port sets the
//   sustained rate; the pipeline takes a new value every cycle unless value_stall is high.
// Stall: when text_stall is high the presented character holds; the pipeline keeps
//   filling until it is full and then raises value_stall. Nothing is lost or repeated.
// Reset: arst_n clears all valid bits and the serializer control; no value is in flight after it.
`default_nettype none

module signed_int_to_decimal_ascii (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic signed [31:0] value,
	input  wire logic               value_valid,
	output logic                    value_stall,
	output logic [7:0]              text_char,
	output logic                    last_char,
	output logic                    text_valid,
	input  wire logic               text_stall
);

	// Pipeline registers.
	logic                          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                          neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [itoa_pkg::MagW-1:0]     mag_s1;
	itoa_pkg::dd_t                 dd_s2, dd_s3, dd_s4, dd_s5;
	logic                          rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	// Serializer registers.
	logic                          busy_q;
	logic                          minus_q;
	logic [itoa_pkg::DigitIdxW-1:0] idx_q;
	logic [itoa_pkg::BcdW-1:0]     bcd_q;
	logic [3:0]                    cur_digit;
	logic                          out_take;
	logic                          ser_ready;
	logic                          ser_load;
	itoa_pkg::dd_t                 dd_in;

	// Backpressure chain: a stage may take new data when it is empty or its content moves on.
	assign out_take  = text_valid && !text_stall;
	assign ser_ready = !busy_q || (out_take && last_char);
	assign ser_load  = vld_s5 && ser_ready;
	assign rdy_s5    = !vld_s5 || ser_ready;
	assign rdy_s4    = !vld_s4 || rdy_s5;
	assign rdy_s3    = !vld_s3 || rdy_s4;
	assign rdy_s2    = !vld_s2 || rdy_s3;
	assign rdy_s1    = !vld_s1 || rdy_s2;
	assign value_stall = !rdy_s1;

	assign dd_in.bcd = '0;
	assign dd_in.bin = mag_s1;

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= value_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
		end
	end

	// Pipeline payload: magnitude, then four groups of BCD conversion steps.
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			neg_s1 <= value[31];
			mag_s1 <= value[31] ? (32'd0 - $unsigned(value)) : $unsigned(value);
		end
		if (rdy_s2) begin
			neg_s2 <= neg_s1;
			dd_s2  <= itoa_pkg::dd_steps(dd_in);
		end
		if (rdy_s3) begin
			neg_s3 <= neg_s2;
			dd_s3  <= itoa_pkg::dd_steps(dd_s2);
		end
		if (rdy_s4) begin
			neg_s4 <= neg_s3;
			dd_s4  <= itoa_pkg::dd_steps(dd_s3);
		end
		if (rdy_s5) begin
			neg_s5 <= neg_s4;
			dd_s5  <= itoa_pkg::dd_steps(dd_s4);
		end
	end

	// Serializer control: load a converted value, then walk from the sign down the digits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			minus_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (ser_load) begin
				busy_q  <= 1'b1;
				minus_q <= neg_s5;
				idx_q   <= itoa_pkg::top_digit(dd_s5.bcd);
			end else if (out_take) begin
				if (minus_q) begin
					minus_q <= 1'b0;
				end else if (idx_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q - 1'b1;
				end
			end
		end
	end

	// Serializer digit store.
	always_ff @(posedge clk) begin
		if (ser_load) begin
			bcd_q <= dd_s5.bcd;
		end
	end

	// Output character selection from the serializer registers.
	assign cur_digit  = bcd_q[idx_q*4 +: 4];
	assign text_valid = busy_q;
	assign text_char  = minus_q ? itoa_pkg::CharMinus : (itoa_pkg::CharZero + {4'd0, cur_digit});
	assign last_char  = !minus_q && (idx_q == '0);

`ifndef SYNTHESIS
	// The sign is never the final character.
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(text_valid && text_char == itoa_pkg::CharMinus) |-> !last_char)
		else $error("minus sign flagged as last character");

	// Characters are only the minus sign or decimal digits.
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid |-> (text_char == itoa_pkg::CharMinus ||
			(text_char >= itoa_pkg::CharZero && text_char <= itoa_pkg::CharZero + 8'd9)))
		else $error("output character outside sign and digits");

	// The input only stalls when the first stage holds a value.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		value_stall |-> vld_s1)
		else $error("input stalled with empty first stage");

	// After the last character leaves with nothing waiting, the output goes idle.
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && last_char && !vld_s5) |=> !text_valid)
		else $error("output still valid after last character");

	// A loaded value always shows on the output in the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ser_load |=> text_valid)
		else $error("loaded value not presented");
`endif

endmodule

`default_nettype wire
